/* hw/rtl/mfhc_pkg.sv */
`timescale 1ns / 1ps

package mfhc_pkg;

  localparam int unsigned CountWidth = 33;
  localparam int unsigned HdrBytes   = 12;

  localparam logic [31:0] MaxFrameReset = 32'd65536;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [7:0] VersionOk = 8'd1;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRUNC    = 3'd1,
    ERR_MAGIC    = 3'd2,
    ERR_VERSION  = 3'd3,
    ERR_TYPE     = 3'd4,
    ERR_RESERVED = 3'd5,
    ERR_LIMIT    = 3'd6,
    ERR_TRAILING = 3'd7
  } err_t;

  // Header byte offsets
  localparam logic [31:0] OffVersion  = 32'd4;
  localparam logic [31:0] OffType     = 32'd5;
  localparam logic [31:0] OffReserved = 32'd6;
  localparam logic [31:0] OffLength   = 32'd8;
  localparam logic [31:0] OffPayload  = 32'd12;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h44;
      2'd1:    b = 8'h4C;
      2'd2:    b = 8'h4F;
      2'd3:    b = 8'h47;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic type_known(input logic [7:0] t);
    return (t == 8'd1) || (t == 8'd2) || (t == 8'd16) || (t == 8'd17) ||
           (t == 8'd18) || (t == 8'd19);
  endfunction

endpackage

/* hw/rtl/mfhc_if.sv */
`timescale 1ns / 1ps

interface mfhc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface mfhc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  error_code;
  logic [31:0] fault_offset;
  logic [7:0]  frame_type;
  logic [31:0] payload_length;

  modport source (output valid, output error_code, output fault_offset,
                  output frame_type, output payload_length, input ready);
  modport sink   (input valid, input error_code, input fault_offset,
                  input frame_type, input payload_length, output ready);
endinterface

/* hw/rtl/message_frame_header_checker.sv */
`timescale 1ns / 1ps

// channel  dir  payload                                           beat
// frame    in   data_byte[8] has_byte[1] last[1]                  one frame byte
// result   out  error_code[3] fault_offset[32] frame_type[8]
//               payload_length[32]                                one per frame
// cfg      in   cfg_write_en, cfg_write_data[32]                  frame size limit
//
// One byte per cycle; each beat is held in the input register, and the
// end-of-frame verdict is registered from there into the result register.
// Throughput: the single input stage takes a new beat every cycle unless stalled.
// Input ready drops only while a last beat waits in the input stage for a full
// result register that is not being taken; beats behind it wait with it.
// rst (synchronous) clears all frame state and sets the frame size limit to 65536.

module message_frame_header_checker
  import mfhc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mfhc_byte_if.sink          frame,
  mfhc_result_if.source      result,
  input  logic               cfg_write_en,
  input  logic [31:0]        cfg_write_data
);

  logic [31:0] frame_size_limit;

  // input stage
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_has;
  logic       s_last;

  // frame state
  logic [CountWidth-1:0] byte_count;
  err_t                  early_error;
  logic [31:0]           early_error_offset;
  logic [7:0]            version_seen;
  logic [7:0]            type_seen;
  logic [15:0]           reserved_seen;
  logic [31:0]           length_seen;

  logic [CountWidth-1:0] byte_count_next;
  err_t                  early_error_next;
  logic [31:0]           early_error_offset_next;
  logic [7:0]            version_seen_next;
  logic [7:0]            type_seen_next;
  logic [15:0]           reserved_seen_next;
  logic [31:0]           length_seen_next;

  // result register
  logic        o_valid;
  err_t        o_code;
  logic [31:0] o_offset;
  logic [7:0]  o_type;
  logic [31:0] o_length;

  err_t        res_code;
  logic [31:0] res_offset;

  logic out_free;
  logic s_go;

  logic [CountWidth:0] total_ext;
  logic [CountWidth:0] max_ext;
  logic [CountWidth:0] len_end;
  logic [31:0]         limit;

  assign out_free    = !o_valid || result.ready;
  assign s_go        = s_valid && (!s_last || out_free);
  assign frame.ready = !s_valid || s_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size_limit <= MaxFrameReset;
    end else if (cfg_write_en) begin
      frame_size_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (frame.ready) begin
      s_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      s_byte <= frame.data_byte;
      s_has  <= frame.has_byte;
      s_last <= frame.last;
    end
  end

  // fold the staged byte into the header record
  always_comb begin
    byte_count_next         = byte_count;
    early_error_next        = early_error;
    early_error_offset_next = early_error_offset;
    version_seen_next       = version_seen;
    type_seen_next          = type_seen;
    reserved_seen_next      = reserved_seen;
    length_seen_next        = length_seen;
    if (s_has) begin
      if (byte_count < CountWidth'(4)) begin
        if (early_error == ERR_NONE && s_byte != magic_byte(byte_count[1:0])) begin
          early_error_next        = ERR_MAGIC;
          early_error_offset_next = byte_count[31:0];
        end
      end else if (byte_count == CountWidth'(4)) begin
        version_seen_next = s_byte;
      end else if (byte_count == CountWidth'(5)) begin
        type_seen_next = s_byte;
      end else if (byte_count < CountWidth'(8)) begin
        reserved_seen_next = {reserved_seen[7:0], s_byte};
      end else if (byte_count < CountWidth'(HdrBytes)) begin
        length_seen_next = {length_seen[23:0], s_byte};
      end
      if (byte_count != CountMax) begin
        byte_count_next = byte_count + CountWidth'(1);
      end
    end
  end

  // end-of-frame verdict
  always_comb begin
    total_ext = {1'b0, byte_count_next};
    max_ext   = {2'b00, frame_size_limit};
    len_end   = {2'b00, length_seen_next} + (CountWidth + 1)'(HdrBytes);
    limit     = (frame_size_limit < 32'(HdrBytes)) ? 32'd0
                                                   : frame_size_limit - 32'(HdrBytes);
    res_code   = ERR_NONE;
    res_offset = 32'd0;
    if (total_ext > max_ext) begin
      res_code = ERR_LIMIT;
    end else if (early_error_next != ERR_NONE) begin
      res_code   = early_error_next;
      res_offset = early_error_offset_next;
    end else if (byte_count_next < CountWidth'(HdrBytes)) begin
      res_code   = ERR_TRUNC;
      res_offset = byte_count_next[31:0];
    end else if (version_seen_next != VersionOk) begin
      res_code   = ERR_VERSION;
      res_offset = OffVersion;
    end else if (!type_known(type_seen_next)) begin
      res_code   = ERR_TYPE;
      res_offset = OffType;
    end else if (reserved_seen_next != 16'd0) begin
      res_code   = ERR_RESERVED;
      res_offset = OffReserved;
    end else if (length_seen_next > limit) begin
      res_code   = ERR_LIMIT;
      res_offset = OffLength;
    end else if (len_end > total_ext) begin
      // length + 12 vs total, same as length vs total - 12
      res_code   = ERR_TRUNC;
      res_offset = OffPayload;
    end else if (len_end < total_ext) begin
      res_code   = ERR_TRAILING;
      res_offset = len_end[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      early_error        <= ERR_NONE;
      early_error_offset <= '0;
      version_seen       <= '0;
      type_seen          <= '0;
      reserved_seen      <= '0;
      length_seen        <= '0;
    end else if (s_go) begin
      if (s_last) begin
        byte_count         <= '0;
        early_error        <= ERR_NONE;
        early_error_offset <= '0;
        version_seen       <= '0;
        type_seen          <= '0;
        reserved_seen      <= '0;
        length_seen        <= '0;
      end else begin
        byte_count         <= byte_count_next;
        early_error        <= early_error_next;
        early_error_offset <= early_error_offset_next;
        version_seen       <= version_seen_next;
        type_seen          <= type_seen_next;
        reserved_seen      <= reserved_seen_next;
        length_seen        <= length_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_go && s_last) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && s_last) begin
      o_code   <= res_code;
      o_offset <= res_offset;
      o_type   <= (res_code == ERR_NONE) ? type_seen_next : 8'd0;
      o_length <= (res_code == ERR_NONE) ? length_seen_next : 32'd0;
    end
  end

  assign result.valid          = o_valid;
  assign result.error_code     = o_code;
  assign result.fault_offset   = o_offset;
  assign result.frame_type     = o_type;
  assign result.payload_length = o_length;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mfhc_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldOff    = 4;
  localparam logic [31:0] Magic      = 32'h444C4F47;
  localparam logic [47:0] KnownTypes = {8'd1, 8'd2, 8'd16, 8'd17, 8'd18, 8'd19};

  typedef struct packed {
    err_t        code;
    logic [31:0] offset;
    logic [7:0]  ftype;
    logic [31:0] plen;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  logic [31:0] cfg_write_data;

  mfhc_byte_if   frame_if ();
  mfhc_result_if result_if ();

  message_frame_header_checker u_top (
    .clk            (clk),
    .rst            (rst),
    .frame          (frame_if),
    .result         (result_if),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #2 clk = ~clk;

  // frame state as the checker should see it
  logic [31:0] frame_limit;
  logic [32:0] seen_bytes;
  err_t        first_err;
  logic [31:0] first_err_at;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_type;
  logic [15:0] hdr_reserved;
  logic [31:0] hdr_length;

  verdict_t    pending_verdicts[$];
  verdict_t    want;
  logic [7:0]  frame_buf[$];

  int unsigned fail_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;
  logic [9:0]  rx_cycle     = '0;

  task clear_frame_view();
    seen_bytes   = '0;
    first_err    = ERR_NONE;
    first_err_at = '0;
    hdr_version  = '0;
    hdr_type     = '0;
    hdr_reserved = '0;
    hdr_length   = '0;
  endtask

  task track_frame_beat(input logic [7:0] d, input logic h, input logic l);
    verdict_t    v;
    logic [31:0] pay_room;
    logic [32:0] body;
    int          idx;
    if (h) begin
      idx = int'(seen_bytes[1:0]);
      if (seen_bytes < 33'd4) begin
        if (first_err == ERR_NONE && d != Magic[8*(3-idx) +: 8]) begin
          first_err    = ERR_MAGIC;
          first_err_at = seen_bytes[31:0];
        end
      end else if (seen_bytes == 33'd4) begin
        hdr_version = d;
      end else if (seen_bytes == 33'd5) begin
        hdr_type = d;
      end else if (seen_bytes == 33'd6 || seen_bytes == 33'd7) begin
        hdr_reserved = {hdr_reserved[7:0], d};
      end else if (seen_bytes < 33'd12) begin
        hdr_length = {hdr_length[23:0], d};
      end
      if (seen_bytes != '1) seen_bytes = seen_bytes + 33'd1;
    end
    if (l) begin
      v.code   = ERR_NONE;
      v.offset = '0;
      pay_room = (frame_limit < 32'd12) ? 32'd0 : frame_limit - 32'd12;
      body     = seen_bytes - 33'd12;
      if (seen_bytes > {1'b0, frame_limit}) begin
        v.code = ERR_LIMIT;
      end else if (first_err != ERR_NONE) begin
        v.code   = first_err;
        v.offset = first_err_at;
      end else if (seen_bytes < 33'd12) begin
        v.code   = ERR_TRUNC;
        v.offset = seen_bytes[31:0];
      end else if (hdr_version != 8'd1) begin
        v.code   = ERR_VERSION;
        v.offset = OffVersion;
      end else if (!(hdr_type == 8'd1 || hdr_type == 8'd2 ||
                     (hdr_type >= 8'd16 && hdr_type <= 8'd19))) begin
        v.code   = ERR_TYPE;
        v.offset = OffType;
      end else if (hdr_reserved != 16'd0) begin
        v.code   = ERR_RESERVED;
        v.offset = OffReserved;
      end else if (hdr_length > pay_room) begin
        v.code   = ERR_LIMIT;
        v.offset = OffLength;
      end else if ({1'b0, hdr_length} > body) begin
        v.code   = ERR_TRUNC;
        v.offset = OffPayload;
      end else if ({1'b0, hdr_length} < body) begin
        v.code   = ERR_TRAILING;
        v.offset = OffPayload + hdr_length;
      end
      v.ftype = (v.code == ERR_NONE) ? hdr_type : 8'd0;
      v.plen  = (v.code == ERR_NONE) ? hdr_length : 32'd0;
      pending_verdicts.insert(pending_verdicts.size(), v);
      frames_sent++;
      clear_frame_view();
    end
  endtask

  // sender idles in bursts
  task pace();
    int unsigned gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task send_beat(input logic [7:0] d, input logic h, input logic l);
    frame_if.valid     <= 1'b1;
    frame_if.data_byte <= d;
    frame_if.has_byte  <= h;
    frame_if.last      <= l;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
    track_frame_beat(d, h, l);
    if (h) bytes_sent++;
    pace();
  endtask

  task wait_drained();
    frame_if.valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task write_limit(input logic [31:0] v);
    wait_drained();
    repeat (HoldOff) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    frame_limit = v;
  endtask

  task add_byte(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endtask

  task set_length(input logic [31:0] v);
    frame_buf[8]  = v[31:24];
    frame_buf[9]  = v[23:16];
    frame_buf[10] = v[15:8];
    frame_buf[11] = v[7:0];
  endtask

  task put_header(input logic [7:0] ver, input logic [7:0] typ, input logic [15:0] rsv,
                  input logic [31:0] len);
    frame_buf.delete();
    for (int i = 3; i >= 0; i--) add_byte(Magic[8*i +: 8]);
    add_byte(ver);
    add_byte(typ);
    add_byte(rsv[15:8]);
    add_byte(rsv[7:0]);
    repeat (4) add_byte(8'h00);
    set_length(len);
  endtask

  // noisy frames get stray markers and sometimes a bare end marker
  task send_frame(input bit noisy);
    int n;
    n = frame_buf.size();
    if (n == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (i != n - 1) begin
        send_beat(frame_buf[i], 1'b1, 1'b0);
      end else if (noisy && $urandom_range(0, 7) == 0) begin
        send_beat(frame_buf[i], 1'b1, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        send_beat(frame_buf[i], 1'b1, 1'b1);
      end
    end
  endtask

  task build_random_frame();
    int unsigned plen;
    int unsigned cut;
    int unsigned idx;
    logic [7:0]  t;
    plen = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
    t    = KnownTypes[8*$urandom_range(0, 5) +: 8];
    put_header(8'd1, t, 16'h0000, plen);
    repeat (plen) add_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 15))
      0: begin
        idx = $urandom_range(0, 3);
        frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
      end
      1: frame_buf[4] = 8'($urandom_range(0, 255));
      2: frame_buf[5] = 8'($urandom_range(0, 255));
      3: frame_buf[6 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
      4: set_length($urandom());
      5: begin
        if (plen > 0 && $urandom_range(0, 1) == 1) set_length(plen - 1);
        else set_length(plen + $urandom_range(1, 3));
      end
      6: begin
        cut = $urandom_range(0, frame_buf.size() - 1);
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
      7: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  task test_bare_and_empty();
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task test_magic();
    frame_buf.delete();
    add_byte(8'h44);
    add_byte(8'h00);
    add_byte(8'hFF);
    send_frame(1'b0);
    frame_buf.delete();
    add_byte(8'hBB);
    send_frame(1'b0);
  endtask

  task test_short_header();
    put_header(8'd1, 8'd1, 16'h0000, 32'd0);
    while (frame_buf.size() > 5) void'(frame_buf.pop_back());
    send_frame(1'b0);
  endtask

  task test_header_fields();
    put_header(8'd0, 8'd17, 16'h0000, 32'd0);
    send_frame(1'b0);
    put_header(8'd1, 8'hFF, 16'h0000, 32'd0);
    send_frame(1'b0);
    put_header(8'd1, 8'd18, 16'h8001, 32'd0);
    send_frame(1'b0);
  endtask

  task test_payload_size();
    put_header(8'd1, 8'd19, 16'h0000, 32'd2);
    add_byte(8'hAA);
    add_byte(8'h55);
    send_frame(1'b0);
    put_header(8'd1, 8'd1, 16'h0000, 32'd3);
    add_byte(8'h00);
    send_frame(1'b0);
    put_header(8'd1, 8'd2, 16'h0000, 32'd0);
    add_byte(8'hFF);
    add_byte(8'hFF);
    send_frame(1'b0);
    put_header(8'd1, 8'd16, 16'h0000, 32'hFFFF_FFFF);
    send_frame(1'b0);
  endtask

  task test_frame_limits();
    write_limit(32'd0);
    send_beat(8'h5A, 1'b0, 1'b1);
    write_limit(32'd11);
    put_header(8'd1, 8'd1, 16'h0000, 32'd0);
    send_frame(1'b0);
    write_limit(32'd12);
    send_frame(1'b0);
    write_limit(32'd13);
    put_header(8'd1, 8'd2, 16'h0000, 32'd2);
    add_byte(8'h01);
    send_frame(1'b0);
    write_limit(32'hFFFF_FFFF);
    put_header(8'd1, 8'd1, 16'h0000, 32'hFFFF_FFFF);
    send_frame(1'b0);
    put_header(8'd1, 8'd1, 16'h0000, 32'hFFFF_FFF3);
    send_frame(1'b0);
  endtask

  task test_random_frames();
    logic [31:0] lim;
    int unsigned start_bytes;
    int unsigned start_frames;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       lim = MaxFrameReset;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = $urandom_range(12, 40);
        3:       lim = $urandom_range(0, 11);
        4:       lim = $urandom();
        default: lim = $urandom_range(20, 64);
      endcase
      write_limit(lim);
      steady       = (phase == 1);
      start_bytes  = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < 40 || frames_sent - start_frames < 3) begin
        build_random_frame();
        send_frame(1'b1);
        // hold off once mid-phase until the pipe is empty
        if (phase == 2 && frames_sent - start_frames == 3) wait_drained();
      end
    end
    steady = 1'b0;
  endtask

  task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none actual code %0d", $time,
                 result_if.error_code);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("error_code", 32'(want.code), 32'(result_if.error_code));
        check_field("fault_offset", want.offset, result_if.fault_offset);
        check_field("frame_type", 32'(want.ftype), 32'(result_if.frame_type));
        check_field("payload_length", want.plen, result_if.payload_length);
      end
    end
  end

  // receiver stalls on a rotating pattern
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 10'd1;
    case (rx_cycle[9:8])
      2'd0:    result_if.ready <= 1'b1;
      2'd1:    result_if.ready <= ($urandom_range(0, 1) == 1);
      2'd2:    result_if.ready <= (rx_cycle[2:0] == 3'd0);
      default: result_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_write_en       <= 1'b0;
    cfg_write_data     <= '0;
    frame_if.valid     <= 1'b0;
    frame_if.data_byte <= '0;
    frame_if.has_byte  <= 1'b0;
    frame_if.last      <= 1'b0;
    frame_limit = MaxFrameReset;
    clear_frame_view();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bare_and_empty();
    test_magic();
    test_short_header();
    test_header_fields();
    test_payload_size();
    test_frame_limits();
    test_random_frames();

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* message_frame_header_checker.f */
hw/rtl/mfhc_pkg.sv
hw/rtl/mfhc_if.sv
hw/rtl/message_frame_header_checker.sv
sim/tb_top.sv
